[rtl/afl_pkg.sv]
// Shared types and constants for the ASID free-list allocator.
package afl_pkg;

  localparam int ID_W       = 8;
  localparam int LINK_DEPTH = 256;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_READ
  } afl_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic pop_issue;   // read the link at the head
    logic pop_finish;  // advance the head, load the popped id as the result
    logic push;        // link the released id in front of the head
    logic load_zero;   // load a zero result
  } afl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic alloc_go;    // allocate request with identifiers enabled
    logic push_go;     // free request for an id in range
  } afl_stat_t;

endpackage

[rtl/afl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module afl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/afl_dp.sv]
// Datapath: head register, link memory with valid bits, enable and result registers.
module afl_dp import afl_pkg::*; #(
  parameter int MAX_ID = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            kind,
  input  logic [ID_W-1:0] release_id,
  input  afl_cmd_t        cmd,
  output afl_stat_t       stat,
  output logic [ID_W-1:0] granted_id
);

  localparam logic [ID_W-1:0] MaxId = ID_W'(MAX_ID);

  logic                  enabled;
  logic [ID_W-1:0]       head;
  logic [ID_W-1:0]       head_next;
  logic [LINK_DEPTH-1:0] link_valid;
  logic [ID_W-1:0]       pend_id;
  logic                  pend_valid;
  logic [ID_W-1:0]       rd_data;
  logic [ID_W-1:0]       init_link;

  assign stat.alloc_go = (kind == KIND_ALLOC) && enabled;
  assign stat.push_go  = (kind == KIND_FREE) && (release_id != '0) && (release_id <= MaxId);

  afl_ram #(
    .WIDTH (ID_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (release_id),
    .wr_data (head),
    .rd_en   (cmd.pop_issue),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  // Untouched entries still hold the power-up chain.
  always_comb begin
    if ((pend_id != '0) && (pend_id < MaxId)) begin
      init_link = pend_id + ID_W'(1);
    end else begin
      init_link = '0;
    end
  end

  always_comb begin
    head_next = head;
    if (cmd.push) begin
      head_next = release_id;
    end else if (cmd.pop_finish) begin
      head_next = pend_valid ? rd_data : init_link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b1;
      head       <= ID_W'(1);
      link_valid <= '0;
    end else begin
      if (cfg_wr_en) begin
        enabled <= cfg_wr_data;
      end
      head <= head_next;
      if (cmd.push) begin
        link_valid[release_id] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_issue) begin
      pend_id    <= head;
      pend_valid <= link_valid[head];
    end
    if (cmd.pop_finish) begin
      granted_id <= pend_id;
    end else if (cmd.load_zero) begin
      granted_id <= '0;
    end
  end

endmodule

[rtl/afl_ctrl.sv]
// Controller: request sequencing and the result valid flag.
module afl_ctrl import afl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  afl_stat_t stat,
  output afl_cmd_t  cmd
);

  afl_state_t state;
  afl_state_t state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        // Take a beat once the result slot is empty or draining.
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          if (stat.alloc_go) begin
            cmd.pop_issue = 1'b1;
            state_next    = ST_READ;
          end else begin
            cmd.push       = stat.push_go;
            cmd.load_zero  = 1'b1;
            out_valid_next = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.pop_finish = 1'b1;
        out_valid_next = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/asid_free_list_allocator.sv]
// Top level of the ASID free-list allocator.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   kind, release_id
//   out      output     out_valid / out_ready granted_id
//   cfg      input      cfg_wr_en             cfg_wr_data (asid_enabled)
//
// A free, or an allocate while disabled, is answered from the idle state; an allocate
// goes through the read state for the registered read of the link RAM at the head
// before the head advances. The result sits in an output register; the next beat is
// taken as it drains. Reset clears the link valid bits, so every entry reads its
// power-up chain value until it is next written. No clearing pass.
// A stalled output holds the result and blocks new input beats.
module asid_free_list_allocator import afl_pkg::*; #(
  parameter int MAX_ID = 255
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            kind,
  input  logic [ID_W-1:0] release_id,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [ID_W-1:0] granted_id
);

  afl_cmd_t  cmd;
  afl_stat_t stat;

  afl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  afl_dp #(
    .MAX_ID (MAX_ID)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (kind),
    .release_id  (release_id),
    .cmd         (cmd),
    .stat        (stat),
    .granted_id  (granted_id)
  );

endmodule

[rtl/afl_checker.sv]
// Port-level checker for the ASID free-list allocator, bound to the top level.
module afl_checker import afl_pkg::*; #(
  parameter int MAX_ID = 255
) (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_ready,
  input logic            kind,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] granted_id
);

  localparam logic [ID_W-1:0] MaxId = ID_W'(MAX_ID);

  // Never take a beat while an unread result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while result stalled");

  // A free always answers zero on the next cycle.
  a_free_zero: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_FREE) |=> (out_valid && granted_id == '0))
    else $error("free beat did not yield a zero result");

  // An allocate either answers at once (disabled) or blocks input while it reads.
  a_alloc_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && kind == KIND_ALLOC) |=> (!in_ready || out_valid))
    else $error("input taken during allocate read");

  // Granted ids stay within the identifier range.
  a_id_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (granted_id <= MaxId))
    else $error("granted id above maximum");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(granted_id)))
    else $error("stalled result changed");

endmodule

bind asid_free_list_allocator afl_checker #(.MAX_ID(MAX_ID)) u_afl_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .kind       (kind),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .granted_id (granted_id)
);
